@@ design/cdsv_pkg.sv @@
// shared types, constants and character helpers for the date string validator
package cdsv_pkg;

    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned DATE_W      = 27;
    localparam int unsigned STATUS_W    = 4;
    localparam int unsigned COUNT_W     = 4;
    localparam int unsigned STORE_LEN   = 10;
    localparam int unsigned COUNT_SAT   = 11;
    localparam int unsigned DASH_POS_A  = 4;
    localparam int unsigned DASH_POS_B  = 7;
    localparam int unsigned FIFO_DEPTH  = 2;
    localparam int unsigned FIFO_PTR_W  = 1;
    localparam int unsigned FIFO_CNT_W  = 2;

    typedef logic [CHAR_W-1:0] char_t;

    localparam char_t CH_DASH = 8'h2D;
    localparam char_t CH_ZERO = 8'h30;
    localparam char_t CH_NINE = 8'h39;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 4'd0,
        ST_EMPTY   = 4'd1,
        ST_BADCHAR = 4'd2,
        ST_FORMAT  = 4'd3,
        ST_YEAR    = 4'd4,
        ST_MONTH   = 4'd5,
        ST_DAY     = 4'd6,
        ST_LEAP    = 4'd7,
        ST_EARLY   = 4'd8
    } status_t;

    typedef struct packed {
        char_t char_code;
        logic  no_char;
        logic  is_last;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATE_W-1:0]   date_value;
    } out_item_t;

    // one finished string handed from the front to the back
    typedef struct packed {
        status_t                    pre_status;
        char_t [STORE_LEN-1:0]      chars;
    } job_t;

    function automatic logic is_digit(char_t c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // low nibble of an ascii digit is its value
    function automatic logic [3:0] digit_val(char_t c);
        return c[3:0];
    endfunction

endpackage

@@ design/cdsv_front.sv @@
// front end: character capture, counting and early classification of each string
module cdsv_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cdsv_pkg::in_item_t in_data,
    output logic              job_valid,
    input  logic              job_ready,
    output cdsv_pkg::job_t    job
);
    import cdsv_pkg::*;

    logic [COUNT_W-1:0] count_reg, count_next, count_seen;
    logic               bad_reg, bad_next, bad_seen;
    char_t              store_reg [STORE_LEN];
    logic               accept, take_char;
    status_t            pre_status;

    assign in_ready  = job_ready;
    assign accept    = in_valid && in_ready;
    assign take_char = accept && !in_data.no_char;
    assign job_valid = accept && in_data.is_last;

    always_comb
    begin
        bad_seen   = bad_reg;
        count_seen = count_reg;
        if (take_char)
        begin
            if (!is_digit(in_data.char_code) && (in_data.char_code != CH_DASH))
                bad_seen = 1'b1;
            if (count_reg < COUNT_W'(COUNT_SAT))
                count_seen = count_reg + COUNT_W'(1);
        end
        // view of the store including this cycle's character
        for (int i = 0; i < STORE_LEN; i++)
        begin
            if (take_char && (count_reg == COUNT_W'(i)))
                job.chars[i] = in_data.char_code;
            else
                job.chars[i] = store_reg[i];
        end
        if (count_seen == '0)
            pre_status = ST_EMPTY;
        else if (bad_seen)
            pre_status = ST_BADCHAR;
        else if ((count_seen != COUNT_W'(STORE_LEN)) ||
                 (job.chars[DASH_POS_A] != CH_DASH) ||
                 (job.chars[DASH_POS_B] != CH_DASH))
            pre_status = ST_FORMAT;
        else
            pre_status = ST_OK;
        job.pre_status = pre_status;

        if (job_valid)
        begin
            count_next = '0;
            bad_next   = 1'b0;
        end
        else
        begin
            count_next = count_seen;
            bad_next   = bad_seen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            bad_reg   <= bad_next;
        end
    end

    // character store, first ten characters only
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STORE_LEN; i++)
        begin
            if (take_char && (count_reg == COUNT_W'(i)))
                store_reg[i] <= in_data.char_code;
        end
    end

endmodule

@@ design/cdsv_fifo.sv @@
// two-entry queue of finished strings between front and back
module cdsv_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  cdsv_pkg::job_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output cdsv_pkg::job_t pop_data
);
    import cdsv_pkg::*;

    job_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  do_push, do_pop;

    assign push_ready = (count_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + FIFO_CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - FIFO_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

@@ design/cdsv_back.sv @@
// back end: field decode, calendar checks and date compare in a stalling pipeline
module cdsv_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    output logic                          job_ready,
    input  cdsv_pkg::job_t                job,
    input  logic [cdsv_pkg::DATE_W-1:0]   min_date,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cdsv_pkg::out_item_t           out_data
);
    import cdsv_pkg::*;

    localparam int unsigned MAG_W  = 7;
    localparam int unsigned YEAR_W = 14;
    localparam int unsigned BCD4_W = 16;
    localparam int unsigned BCD8_W = 32;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } field_t;

    // atoi over a two character field made of digits and dashes
    function automatic field_t field2(char_t a, char_t b);
        field_t f;
        f.neg = 1'b0;
        f.mag = '0;
        if (a == CH_DASH)
        begin
            f.neg = 1'b1;
            if (is_digit(b))
                f.mag = MAG_W'(digit_val(b));
        end
        else if (is_digit(a))
        begin
            if (is_digit(b))
                f.mag = MAG_W'(digit_val(a)) * MAG_W'(10) + MAG_W'(digit_val(b));
            else
                f.mag = MAG_W'(digit_val(a));
        end
        return f;
    endfunction

    function automatic logic [YEAR_W-1:0] bcd4_to_bin(logic [BCD4_W-1:0] b);
        return YEAR_W'(b[15:12]) * YEAR_W'(1000) + YEAR_W'(b[11:8]) * YEAR_W'(100)
             + YEAR_W'(b[7:4]) * YEAR_W'(10) + YEAR_W'(b[3:0]);
    endfunction

    logic adv;

    // stage 1: decode
    logic                s1_valid_reg;
    status_t             s1_pre_reg;
    logic                s1_year_neg_reg;
    logic [BCD4_W-1:0]   s1_year_bcd_reg;
    field_t              s1_mon_reg, s1_day_reg;
    logic [BCD8_W-1:0]   s1_joined_bcd_reg;

    logic                year_neg_c, run_c;
    logic [BCD4_W-1:0]   year_bcd_c;
    logic [BCD8_W-1:0]   joined_bcd_c;

    // stage 2: binary values and calendar checks
    logic                s2_valid_reg;
    status_t             s2_pre_reg;
    logic                s2_year_neg_nz_reg;
    logic [YEAR_W-1:0]   s2_year_mag_reg;
    logic                s2_mon_bad_reg, s2_day_bad_reg, s2_leap_bad_reg;
    logic [YEAR_W-1:0]   s2_jhi_reg, s2_jlo_reg;

    logic [YEAR_W-1:0]   year_mag_c;
    logic [3:0]          hund_mod_c, unit_mod_c;
    logic                leap_c, thirty_c, thirty_one_c, feb_c;
    logic                mon_bad_c, day_bad_c, leap_bad_c;

    // stage 3: scaled year and joined date
    logic                s3_valid_reg;
    status_t             s3_pre_reg;
    logic                s3_year_neg_nz_reg;
    logic [DATE_W-1:0]   s3_year_scaled_reg;
    logic                s3_mon_bad_reg, s3_day_bad_reg, s3_leap_bad_reg;
    logic [DATE_W-1:0]   s3_joined_reg;

    // output register
    logic                out_valid_reg;
    out_item_t           out_data_reg;
    status_t             status_c;
    logic                year_low_c;

    assign adv       = !out_valid_reg || out_ready;
    assign job_ready = adv;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        year_neg_c = (job.chars[0] == CH_DASH);
        run_c      = 1'b1;
        year_bcd_c = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (!((i == 0) && year_neg_c))
            begin
                if (run_c && is_digit(job.chars[i]))
                    year_bcd_c = {year_bcd_c[BCD4_W-5:0], digit_val(job.chars[i])};
                else
                    run_c = 1'b0;
            end
        end
        joined_bcd_c = '0;
        for (int i = 0; i < STORE_LEN; i++)
        begin
            if (is_digit(job.chars[i]))
                joined_bcd_c = {joined_bcd_c[BCD8_W-5:0], digit_val(job.chars[i])};
        end
    end

    always_comb
    begin
        year_mag_c = bcd4_to_bin(s1_year_bcd_reg);
        // divisible by 400: last two digits zero and (10*d3 + d2) divisible by 4
        hund_mod_c = {s1_year_bcd_reg[14:12], 1'b0} + s1_year_bcd_reg[11:8];
        unit_mod_c = {s1_year_bcd_reg[6:4], 1'b0} + s1_year_bcd_reg[3:0];
        leap_c = ((unit_mod_c[1:0] == 2'd0) && (s1_year_bcd_reg[7:0] != 8'd0)) ||
                 ((s1_year_bcd_reg[7:0] == 8'd0) && (hund_mod_c[1:0] == 2'd0));
        mon_bad_c = s1_mon_reg.neg || (s1_mon_reg.mag == '0) ||
                    (s1_mon_reg.mag > MAG_W'(12));
        thirty_c = (s1_mon_reg.mag == MAG_W'(4)) || (s1_mon_reg.mag == MAG_W'(6)) ||
                   (s1_mon_reg.mag == MAG_W'(9)) || (s1_mon_reg.mag == MAG_W'(11));
        thirty_one_c = (s1_mon_reg.mag == MAG_W'(1)) || (s1_mon_reg.mag == MAG_W'(3)) ||
                       (s1_mon_reg.mag == MAG_W'(5)) || (s1_mon_reg.mag == MAG_W'(7)) ||
                       (s1_mon_reg.mag == MAG_W'(8)) || (s1_mon_reg.mag == MAG_W'(10)) ||
                       (s1_mon_reg.mag == MAG_W'(12));
        feb_c = (s1_mon_reg.mag == MAG_W'(2));
        day_bad_c = s1_day_reg.neg || (s1_day_reg.mag == '0) ||
                    (thirty_c && (s1_day_reg.mag > MAG_W'(30))) ||
                    (thirty_one_c && (s1_day_reg.mag > MAG_W'(31))) ||
                    (feb_c && !leap_c && (s1_day_reg.mag > MAG_W'(28)));
        leap_bad_c = feb_c && leap_c && (s1_day_reg.mag > MAG_W'(29));
    end

    always_comb
    begin
        // year < min_date / 10000 exactly when (year + 1) * 10000 <= min_date
        year_low_c = s3_year_neg_nz_reg || (s3_year_scaled_reg <= min_date);
        if (s3_pre_reg != ST_OK)
            status_c = s3_pre_reg;
        else if (year_low_c)
            status_c = ST_YEAR;
        else if (s3_mon_bad_reg)
            status_c = ST_MONTH;
        else if (s3_day_bad_reg)
            status_c = ST_DAY;
        else if (s3_leap_bad_reg)
            status_c = ST_LEAP;
        else if (s3_joined_reg < min_date)
            status_c = ST_EARLY;
        else
            status_c = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= job_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pre_reg         <= job.pre_status;
            s1_year_neg_reg    <= year_neg_c;
            s1_year_bcd_reg    <= year_bcd_c;
            s1_mon_reg         <= field2(job.chars[5], job.chars[6]);
            s1_day_reg         <= field2(job.chars[8], job.chars[9]);
            s1_joined_bcd_reg  <= joined_bcd_c;

            s2_pre_reg         <= s1_pre_reg;
            s2_year_neg_nz_reg <= s1_year_neg_reg && (s1_year_bcd_reg != '0);
            s2_year_mag_reg    <= year_mag_c;
            s2_mon_bad_reg     <= mon_bad_c;
            s2_day_bad_reg     <= day_bad_c;
            s2_leap_bad_reg    <= leap_bad_c;
            s2_jhi_reg         <= bcd4_to_bin(s1_joined_bcd_reg[BCD8_W-1:BCD4_W]);
            s2_jlo_reg         <= bcd4_to_bin(s1_joined_bcd_reg[BCD4_W-1:0]);

            s3_pre_reg         <= s2_pre_reg;
            s3_year_neg_nz_reg <= s2_year_neg_nz_reg;
            s3_year_scaled_reg <= (DATE_W'(s2_year_mag_reg) + DATE_W'(1)) * DATE_W'(10000);
            s3_mon_bad_reg     <= s2_mon_bad_reg;
            s3_day_bad_reg     <= s2_day_bad_reg;
            s3_leap_bad_reg    <= s2_leap_bad_reg;
            s3_joined_reg      <= DATE_W'(s2_jhi_reg) * DATE_W'(10000) + DATE_W'(s2_jlo_reg);

            out_data_reg.status     <= status_c;
            out_data_reg.date_value <= (status_c == ST_OK) ? s3_joined_reg : '0;
        end
    end

endmodule

@@ design/calendar_date_string_validator_unit.sv @@
// top level of the calendar date string validator
// checks a YYYY-MM-DD string that arrives one ascii character per input
// transaction and returns one status transaction for each transaction marked
// is_last. a character transaction is accepted every cycle while the queue
// has room; the front end counts and stores the first ten characters, flags
// bad characters and the empty and format cases, then drops each finished
// string into a two-entry queue. the back end is a four-register pipeline
// (decode, calendar checks, scaling, final compare) that stalls only when the
// output register is full and not taken, and input stalls only when that
// stall has also filled the queue. each string passes the queue, s1, s2, s3
// and the output register; one result per cycle can be sustained. min_date
// is written through cfg_we and cfg_wdata and should change only while no
// string is in flight; its year part is the earliest accepted year.
module calendar_date_string_validator_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [cdsv_pkg::DATE_W-1:0] cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  cdsv_pkg::in_item_t          in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output cdsv_pkg::out_item_t         out_data
);
    import cdsv_pkg::*;

    // earliest accepted date, decimal YYYYMMDD
    logic [DATE_W-1:0] min_date_reg, min_date_next;

    // front to queue
    job_t front_job;
    logic front_job_valid;
    logic front_job_ready;

    // queue to back
    job_t q_job;
    logic q_job_valid;
    logic q_job_ready;

    assign min_date_next = cfg_we ? cfg_wdata : min_date_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_date_reg <= '0;
        else
            min_date_reg <= min_date_next;
    end

    // character capture and early classification
    cdsv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .job_valid (front_job_valid),
        .job_ready (front_job_ready),
        .job       (front_job)
    );

    // decouples the front from a stalled back end
    cdsv_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_job_valid),
        .push_ready (front_job_ready),
        .push_data  (front_job),
        .pop_valid  (q_job_valid),
        .pop_ready  (q_job_ready),
        .pop_data   (q_job)
    );

    // field decode, calendar rules and date compare
    cdsv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_job_valid),
        .job_ready (q_job_ready),
        .job       (q_job),
        .min_date  (min_date_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ test/calendar_date_string_validator_unit_tb.sv @@
// self-checking testbench for the calendar date string validator unit
module calendar_date_string_validator_unit_tb;

    import cdsv_pkg::*;

    // a directed row: one date string, optional min_date change before it,
    // and an expected verdict typed in where it is obvious
    typedef struct {
        string                text;
        bit                   gap;       // add character-free transactions
        int                   new_min;   // -1 keeps the current min_date
        bit                   typed;
        status_t              want_st;
        int unsigned          want_val;
    } probe_row_t;

    localparam int NPROBE        = 26;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PCT      = 17;
    localparam int RANDOM_ITEMS  = 1480;
    localparam int NPHASE        = 8;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [DATE_W-1:0]   cfg_wdata;
    logic                in_valid;
    logic                in_ready;
    in_item_t            in_data;
    logic                out_valid;
    logic                out_ready;
    out_item_t           out_data;

    // predictor state: the string being scanned and the active min_date
    char_t               date_chars [STORE_LEN];
    int                  scan_count;
    bit                  scan_bad;
    logic [DATE_W-1:0]   min_date_q;

    // verdicts still owed by the block, oldest first
    out_item_t           pending_verdicts [$];

    // typed verdict for the current directed row
    bit                  typed_on;
    status_t             typed_status;
    int unsigned         typed_value;

    bit                  calm;           // no idling on either side
    int                  errors;
    int                  items_sent;
    int                  strings_sent;
    int                  results_seen;
    int                  ok_seen;
    int                  cfg_writes;

    probe_row_t          probes [NPROBE];
    logic [DATE_W-1:0]   cfg_plan [NPHASE];

    calendar_date_string_validator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // date predictor
    // ------------------------------------------------------------------

    function automatic bit is_numeral(char_t c);
        return (c >= "0") && (c <= "9");
    endfunction

    // atoi over a slice of the stored string: a leading dash negates and
    // the first non-digit after it stops the number
    function automatic int atoi_field(int first, int len);
        int  v;
        int  k;
        bit  neg;
        v   = 0;
        k   = 0;
        neg = 1'b0;
        if (date_chars[first] == CH_DASH)
        begin
            neg = 1'b1;
            k   = 1;
        end
        while (k < len && is_numeral(date_chars[first + k]))
        begin
            v = v * 10 + int'(date_chars[first + k] - CH_ZERO);
            k++;
        end
        return neg ? -v : v;
    endfunction

    // verdict for the string held in the predictor; first failing check wins
    function automatic status_t grade_date(output logic [DATE_W-1:0] joined);
        int           yr;
        int           mo;
        int           dy;
        int           min_yr;
        bit           leap;
        bit           short_month;
        bit           long_month;
        int unsigned  acc;
        joined = '0;
        if (scan_count == 0)
            return ST_EMPTY;
        if (scan_bad)
            return ST_BADCHAR;
        if (scan_count != STORE_LEN || date_chars[DASH_POS_A] != CH_DASH ||
            date_chars[DASH_POS_B] != CH_DASH)
            return ST_FORMAT;
        yr     = atoi_field(0, 4);
        min_yr = int'(min_date_q / 10000);
        if (yr < min_yr)
            return ST_YEAR;
        mo = atoi_field(5, 2);
        if (mo < 1 || mo > 12)
            return ST_MONTH;
        dy          = atoi_field(8, 2);
        short_month = (mo == 4 || mo == 6 || mo == 9 || mo == 11);
        long_month  = !short_month && mo != 2;
        if (dy < 1 || (short_month && dy > 30) || (long_month && dy > 31))
            return ST_DAY;
        // signed remainder follows the dividend, so negative years work too
        leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        if (mo == 2 && leap && dy > 29)
            return ST_LEAP;
        if (mo == 2 && !leap && dy > 28)
            return ST_DAY;
        acc = 0;
        for (int i = 0; i < STORE_LEN; i++)
        begin
            if (is_numeral(date_chars[i]))
                acc = acc * 10 + int'(date_chars[i] - CH_ZERO);
        end
        if (acc < min_date_q)
            return ST_EARLY;
        joined = acc[DATE_W-1:0];
        return ST_OK;
    endfunction

    // fold one accepted character transaction into the predictor
    task automatic take_char(in_item_t it);
        status_t            st;
        logic [DATE_W-1:0]  jv;
        out_item_t          verdict;
        if (!it.no_char)
        begin
            if (!is_numeral(it.char_code) && it.char_code != CH_DASH)
                scan_bad = 1'b1;
            if (scan_count < STORE_LEN)
                date_chars[scan_count] = it.char_code;
            if (scan_count < COUNT_SAT)
                scan_count++;
        end
        if (it.is_last)
        begin
            st = grade_date(jv);
            if (typed_on)
            begin
                verdict.status     = typed_status;
                verdict.date_value = typed_value[DATE_W-1:0];
            end
            else
            begin
                verdict.status     = st;
                verdict.date_value = jv;
            end
            pending_verdicts.push_back(verdict);
            // next transaction starts a fresh string
            scan_count = 0;
            scan_bad   = 1'b0;
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // port monitor: inputs settle at the falling edge, so everything here
    // is stable at the rising edge where transactions happen
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : port_monitor
        out_item_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                take_char(in_data);
            if (out_valid && out_ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    report_mismatch("unexpected result, status", out_data.status, -1);
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    results_seen++;
                    if (want.status == ST_OK)
                        ok_seen++;
                    if (out_data.status != want.status)
                        report_mismatch("status", out_data.status, want.status);
                    if (out_data.date_value != want.date_value)
                        report_mismatch("date_value", out_data.date_value, want.date_value);
                end
            end
        end
    end

    // result side backpressure, off during calm stretches
    always @(negedge clk)
    begin
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // drivers, all called at a falling edge
    // ------------------------------------------------------------------

    // one input transaction, with random idle cycles in front of it;
    // returns at the falling edge after acceptance with valid still high
    task automatic send_item(char_t c, bit nc, bit last);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{char_code: c, no_char: nc, is_last: last};
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        @(negedge clk);
    endtask

    // a whole string; with gap set a character-free transaction sits in the
    // middle and another one closes the string
    task automatic send_text(ref byte unsigned txt[$], input bit gap);
        int n;
        n = txt.size();
        strings_sent++;
        for (int i = 0; i < n; i++)
        begin
            if (gap && i == n / 2)
                send_item(char_t'($urandom), 1'b1, 1'b0);
            send_item(txt[i], 1'b0, !gap && i == n - 1);
        end
        if (gap || n == 0)
            send_item(char_t'($urandom), 1'b1, 1'b1);
    endtask

    // min_date only changes with nothing in flight
    task automatic set_min_date(logic [DATE_W-1:0] v);
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we     <= 1'b0;
        min_date_q  = v;
        cfg_writes++;
    endtask

    // random date string: mostly well formed with random fields, biased
    // toward leap-year boundaries and the minimum year, plus mutations
    // and pure noise
    task automatic make_text(ref byte unsigned txt[$], output bit gap);
        int     yr;
        int     mo;
        int     dy;
        int     min_yr;
        int     pos;
        string  s;
        txt.delete();
        gap = ($urandom_range(9) == 0);
        if ($urandom_range(99) < 8)
        begin
            // noise: random bytes of random length, empty included
            repeat ($urandom_range(13)) txt.push_back(8'($urandom_range(255)));
            return;
        end
        min_yr = int'(min_date_q / 10000);
        case ($urandom_range(3))
            0:       yr = $urandom_range(9999);
            1:       yr = 100 * $urandom_range(99);
            2:       yr = 4 * $urandom_range(2499);
            default: yr = int'(min_yr) + int'($urandom_range(2)) - 1;
        endcase
        if (yr < 0)
            yr = 0;
        if (yr > 9999)
            yr = 9999;
        mo = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(1, 12);
        dy = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(1, 31);
        if ($urandom_range(3) == 0)
        begin
            mo = 2;
            dy = $urandom_range(27, 30);
        end
        s = $sformatf("%04d-%02d-%02d", yr, mo, dy);
        for (int i = 0; i < s.len(); i++)
            txt.push_back(s[i]);
        if ($urandom_range(4) == 0)
        begin
            pos = $urandom_range(txt.size() - 1);
            case ($urandom_range(4))
                0:       txt[pos] = CH_DASH;
                1:       txt[pos] = 8'($urandom_range(255));
                2:       repeat ($urandom_range(1, 3)) txt.push_back(8'("0" + $urandom_range(9)));
                3:       txt.delete(pos);
                default: txt[0] = CH_DASH;     // negative year
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // run limit
    // ------------------------------------------------------------------
    initial
    begin
        #1000000;
        $display("calendar_date_string_validator_unit regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        byte unsigned  txt [$];
        bit            gap;
        int            phase_end;

        clk        = 1'b0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_ready  = 1'b0;
        calm       = 1'b0;
        typed_on   = 1'b0;
        min_date_q = '0;
        scan_count = 0;
        scan_bad   = 1'b0;
        errors     = 0;
        items_sent = 0;
        strings_sent = 0;
        results_seen = 0;
        ok_seen    = 0;
        cfg_writes = 0;
        foreach (date_chars[i])
            date_chars[i] = '0;

        // leap rules, every status, field extremes, dashes inside fields,
        // over-long strings and min_date edges
        probes = '{
            '{"",            0, -1,        1, ST_EMPTY,   0},
            '{"2024-02-29",  0, -1,        1, ST_OK,      20240229},
            '{"2023-02-29",  0, -1,        1, ST_DAY,     0},
            '{"1900-02-29",  0, -1,        1, ST_DAY,     0},
            '{"2000-02-30",  0, -1,        1, ST_LEAP,    0},
            '{"2024-13-01",  0, -1,        1, ST_MONTH,   0},
            '{"2024-00-10",  0, -1,        1, ST_MONTH,   0},
            '{"2024-04-31",  0, -1,        1, ST_DAY,     0},
            '{"0000-01-01",  0, -1,        1, ST_OK,      101},
            '{"9999-12-31",  0, -1,        1, ST_OK,      99991231},
            '{"2024-1a-01",  0, -1,        1, ST_BADCHAR, 0},
            '{"2024-01-01\377", 0, -1,     1, ST_BADCHAR, 0},
            '{"2024-01-011", 0, -1,        1, ST_FORMAT,  0},
            '{"20240-1-01",  0, -1,        1, ST_FORMAT,  0},
            '{"2024-06-3",   1, -1,        1, ST_FORMAT,  0},
            '{"-999-01-01",  0, -1,        1, ST_YEAR,    0},
            '{"2024--1-01",  0, -1,        0, ST_OK,      0},
            '{"2024-1--01",  0, -1,        0, ST_OK,      0},
            '{"2024-02--5",  0, -1,        0, ST_OK,      0},
            '{"----------",  0, -1,        0, ST_OK,      0},
            '{"2024-06-15",  1, -1,        0, ST_OK,      0},
            '{"2023-12-31",  0, 20240315,  1, ST_YEAR,    0},
            '{"2024-03-14",  0, -1,        1, ST_EARLY,   0},
            '{"2024-03-15",  0, -1,        1, ST_OK,      20240315},
            '{"9999-12-31",  0, 134217727, 1, ST_YEAR,    0},
            '{"9999-12-31",  0, 99991231,  1, ST_OK,      99991231}
        };

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (probes[r])
        begin
            if (probes[r].new_min >= 0)
                set_min_date(DATE_W'(probes[r].new_min));
            typed_on     = probes[r].typed;
            typed_status = probes[r].want_st;
            typed_value  = probes[r].want_val;
            txt.delete();
            for (int i = 0; i < probes[r].text.len(); i++)
                txt.push_back(probes[r].text[i]);
            send_text(txt, probes[r].gap);
        end
        typed_on = 1'b0;

        // random part in phases, each under its own min_date
        cfg_plan[0] = '0;
        cfg_plan[1] = 27'd99991231;
        cfg_plan[2] = '1;
        cfg_plan[3] = 27'($urandom_range(99991231));
        cfg_plan[4] = 27'd20000229;
        cfg_plan[5] = 27'($urandom_range(1600, 2400) * 10000 +
                          $urandom_range(1, 12) * 100 + $urandom_range(1, 28));
        cfg_plan[6] = 27'($urandom_range(99991231));
        cfg_plan[7] = '0;
        for (int p = 0; p < NPHASE; p++)
        begin
            set_min_date(cfg_plan[p]);
            calm      = (p == 4);
            phase_end = items_sent + RANDOM_ITEMS / NPHASE;
            while (items_sent < phase_end)
            begin
                make_text(txt, gap);
                send_text(txt, gap);
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        $display("ran %0d strings in %0d character transactions under %0d min_date settings",
                 strings_sent, items_sent, cfg_writes);
        $display("%0d verdicts checked, %0d of them valid dates", results_seen, ok_seen);
        if (errors == 0)
            $display("calendar_date_string_validator_unit regression: pass");
        else
            $display("calendar_date_string_validator_unit regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
design/cdsv_pkg.sv
design/cdsv_front.sv
design/cdsv_fifo.sv
design/cdsv_back.sv
design/calendar_date_string_validator_unit.sv
test/calendar_date_string_validator_unit_tb.sv
